// ===== rtl/empirical_semivariogram_binner_macros.svh =====
// Assertion helpers for the semivariogram binner.
`ifndef EMPIRICAL_SEMIVARIOGRAM_BINNER_MACROS_SVH
`define EMPIRICAL_SEMIVARIOGRAM_BINNER_MACROS_SVH

// Same-cycle implication.
`define ESVB_ASSERT_IMP(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESVB_ASSERT_NXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/esvb_pkg.sv =====
package esvb_pkg;

  localparam int COORD_W   = 16;
  localparam int VAL_W     = 16;
  localparam int LAG_W     = 8;
  localparam int FRAC_W    = 8;
  localparam int DIST_W    = 25;
  localparam int SQ_W      = 33;  // dx^2 + dy^2
  localparam int RAD_W     = 50;  // (dx^2 + dy^2) << 16, padded even
  localparam int ROOT_W    = RAD_W / 2;
  localparam int BIN_IDX_W = 6;
  localparam int CNT_OUT_W = 11;
  localparam int MEAN_D_W  = 25;
  localparam int MEAN_S_W  = 32;

  localparam logic [DIST_W-1:0] LEAST_RESET = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [VAL_W-1:0]   v;
  } point_t;

endpackage

// ===== rtl/esvb_if.sv =====
interface esvb_point_if import esvb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [VAL_W-1:0]   sample_value;
  logic                      last_point;
  modport source (output valid, x_coord, y_coord, sample_value, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, sample_value, last_point, output ready);
endinterface

interface esvb_bin_if import esvb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [CNT_OUT_W-1:0] pair_count;
  logic [MEAN_D_W-1:0]  mean_distance;
  logic [MEAN_S_W-1:0]  mean_semivariance;
  logic                 last_bin;
  modport source (output valid, bin_index, pair_count, mean_distance, mean_semivariance,
                  last_bin, input ready);
  modport sink   (input valid, bin_index, pair_count, mean_distance, mean_semivariance,
                  last_bin, output ready);
endinterface

interface esvb_cfg_if import esvb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LAG_W-1:0] lag_width;
  modport source (output valid, lag_width, input ready);
  modport sink   (input valid, lag_width, output ready);
endinterface

// ===== rtl/esvb_sqrt.sv =====
module esvb_sqrt import esvb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CW = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W:0]   rem_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;

  logic [ROOT_W+2:0] rem_sh, trial, rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
      cnt_q  <= CW'(ROOT_W - 1);
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], ge};
      rem_q  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/esvb_div.sv =====
module esvb_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0] rem_sh, rem_sub;
  logic           ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // quotient bits shift into num_q as numerator bits leave it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= CW'(NUM_W - 1);
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/empirical_semivariogram_binner.sv =====
// Point load: one point per cycle while idle; a point without last_point gives no result.
// Run: bin clear sweep over all MAX_BINS bins, then, for 2+ points, two pair passes (the
//   first uses the 25-step root; the second also the 1-bit divider of SSUM_W steps).
// Output: per bin two divisions on the shared divider, none if the bin is empty.
// Reset: async active low; point count zero, lag_width 1, idle. Bin memory is cleared
//   by the sweep at the start of each run; point memory is not cleared.
module empirical_semivariogram_binner import esvb_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_BINS   = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  esvb_point_if.sink   point_i,
  esvb_cfg_if.sink     cfg_i,
  esvb_bin_if.source   bin_o
);

`include "empirical_semivariogram_binner_macros.svh"

  localparam int IW        = $clog2(MAX_POINTS);
  localparam int NW        = $clog2(MAX_POINTS + 1);
  localparam int BW        = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NBW       = $clog2(MAX_BINS + 1);
  localparam int MAX_PAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int DSUM_W    = DIST_W + CNT_W;
  localparam int SSUM_W    = 2 * VAL_W + CNT_W;
  localparam int DIV_NW    = SSUM_W;
  localparam int DIV_DW    = (CNT_W > LAG_W) ? CNT_W : LAG_W;
  localparam int LO_W      = DIST_W - FRAC_W;
  localparam int HI_W      = LO_W + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_DIVB = 4'd6;
  localparam logic [3:0] S_BRD  = 4'd7;
  localparam logic [3:0] S_NBS  = 4'd8;
  localparam logic [3:0] S_NBD  = 4'd9;
  localparam logic [3:0] S_ORA  = 4'd10;
  localparam logic [3:0] S_ORD  = 4'd11;
  localparam logic [3:0] S_OD1  = 4'd12;
  localparam logic [3:0] S_OD2  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state_q;

  // config
  logic [LAG_W-1:0] lag_q, lag_eff;
  assign cfg_i.ready = 1'b1;
  assign lag_eff = (lag_q == '0) ? LAG_W'(1) : lag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= LAG_W'(1);
    end else if (cfg_i.valid) begin
      lag_q <= cfg_i.lag_width;
    end
  end

  // point memory, two read ports
  point_t pmem [MAX_POINTS];
  point_t pa_q, pb_q;
  logic [NW-1:0] cnt_q, n_q;
  logic [IW-1:0] i_q, j_q;
  logic          pt_xfer, pt_store;

  assign point_i.ready = (state_q == S_IDLE);
  assign pt_xfer  = point_i.valid && point_i.ready;
  assign pt_store = pt_xfer && (cnt_q < NW'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (pt_store) begin
      pmem[cnt_q[IW-1:0]] <= '{x: point_i.x_coord, y: point_i.y_coord,
                               v: point_i.sample_value};
    end
    pa_q <= pmem[i_q];
    pb_q <= pmem[j_q];
  end

  // bin memory
  logic [CNT_W-1:0]  cmem [MAX_BINS];
  logic [DSUM_W-1:0] dmem [MAX_BINS];
  logic [SSUM_W-1:0] smem [MAX_BINS];
  logic [CNT_W-1:0]  rc_q;
  logic [DSUM_W-1:0] rd_q;
  logic [SSUM_W-1:0] rs_q;
  logic [BW-1:0]     k_q, bidx_q, b_raddr, b_waddr, b_clamp;
  logic              b_we;
  logic [CNT_W-1:0]  wc;
  logic [DSUM_W-1:0] wd;
  logic [SSUM_W-1:0] ws;

  // pair datapath
  logic [31:0]        sqx_q, sqy_q, sqv_q;
  logic [DIST_W-1:0]  d_q, d_w, least_q, great_q;
  logic [LO_W-1:0]    lo_q, lo_w;
  logic [HI_W-1:0]    hi_w;
  logic [NBW-1:0]     nbins_q;
  logic               pass_q;

  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               dv_start, dv_done;
  logic [DIV_NW-1:0]  dv_num, dv_quot;
  logic [DIV_DW-1:0]  dv_den;
  logic [MEAN_D_W-1:0] md_q;
  logic [MEAN_S_W-1:0] ms_q;

  logic [COORD_W:0] dx_s, dy_s;
  logic [VAL_W:0]   dv_s;
  logic [15:0]      dx_a, dy_a, dv_a;
  logic             more_j, more_i, last_k;

  always_comb begin
    dx_s = {pa_q.x[COORD_W-1], pa_q.x} - {pb_q.x[COORD_W-1], pb_q.x};
    dy_s = {pa_q.y[COORD_W-1], pa_q.y} - {pb_q.y[COORD_W-1], pb_q.y};
    dv_s = {pa_q.v[VAL_W-1], pa_q.v} - {pb_q.v[VAL_W-1], pb_q.v};
    dx_a = dx_s[COORD_W] ? 16'(-dx_s) : dx_s[15:0];
    dy_a = dy_s[COORD_W] ? 16'(-dy_s) : dy_s[15:0];
    dv_a = dv_s[VAL_W]   ? 16'(-dv_s) : dv_s[15:0];
  end

  // distance less one LSB, floor at zero
  assign d_w = (sq_root == '0) ? '0 : DIST_W'(sq_root - ROOT_W'(1));

  // bin edges; a set of fewer than two points has no spread
  always_comb begin
    if (n_q < NW'(2)) begin
      lo_w = '0;
      hi_w = '0;
    end else begin
      lo_w = least_q[DIST_W-1:FRAC_W];
      hi_w = HI_W'(({1'b0, great_q} + (DIST_W+1)'(255)) >> FRAC_W);
    end
  end

  assign more_j = (NW'(j_q) + NW'(1)) < n_q;
  assign more_i = (NW'(i_q) + NW'(2)) < n_q;
  assign last_k = (NBW'(k_q) + NBW'(1)) == nbins_q;

  assign b_clamp = (dv_quot > DIV_NW'(nbins_q - NBW'(1))) ? BW'(nbins_q - NBW'(1))
                                                         : BW'(dv_quot);

  // root start, divider start and operand select
  always_comb begin
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = DIV_DW'(lag_eff);
    unique case (state_q)
      S_SUM: sq_start = 1'b1;
      S_SQ: begin
        dv_start = sq_done && pass_q;
        dv_num   = DIV_NW'(d_w[DIST_W-1:FRAC_W] - lo_q);
      end
      S_NBS: begin
        dv_start = 1'b1;
        dv_num   = DIV_NW'(hi_w - HI_W'(lo_w));
      end
      S_ORD: begin
        dv_start = (rc_q != '0);
        dv_num   = DIV_NW'(rd_q);
        dv_den   = DIV_DW'(rc_q);
      end
      S_OD1: begin
        dv_start = dv_done;
        dv_num   = rs_q;
        dv_den   = DIV_DW'(rc_q);
      end
      default: begin
      end
    endcase
  end

  // bin memory port control
  always_comb begin
    b_raddr = (state_q == S_DIVB) ? b_clamp : k_q;
    b_we    = (state_q == S_CLR) || (state_q == S_BRD);
    b_waddr = (state_q == S_CLR) ? k_q : bidx_q;
    wc      = (state_q == S_CLR) ? '0 : rc_q + CNT_W'(1);
    wd      = (state_q == S_CLR) ? '0 : rd_q + DSUM_W'(d_q);
    ws      = (state_q == S_CLR) ? '0 : rs_q + SSUM_W'(sqv_q);
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      cmem[b_waddr] <= wc;
      dmem[b_waddr] <= wd;
      smem[b_waddr] <= ws;
    end
    rc_q <= cmem[b_raddr];
    rd_q <= dmem[b_raddr];
    rs_q <= smem[b_raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      sqx_q <= dx_a * dx_a;
      sqy_q <= dy_a * dy_a;
      sqv_q <= dv_a * dv_a;
    end
    if (state_q == S_SQ && sq_done) d_q <= d_w;
    if (state_q == S_DIVB && dv_done) bidx_q <= b_clamp;
    if (state_q == S_NBS) lo_q <= lo_w;
    if (state_q == S_ORD && rc_q == '0) begin
      md_q <= '0;
      ms_q <= '0;
    end
    if (state_q == S_OD1 && dv_done) md_q <= dv_quot[MEAN_D_W-1:0];
    if (state_q == S_OD2 && dv_done) ms_q <= dv_quot[MEAN_S_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      pass_q  <= 1'b0;
      least_q <= LEAST_RESET;
      great_q <= '0;
      nbins_q <= NBW'(1);
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pt_xfer) begin
            if (point_i.last_point) begin
              n_q     <= pt_store ? cnt_q + NW'(1) : cnt_q;
              cnt_q   <= '0;
              k_q     <= '0;
              state_q <= S_CLR;
            end else if (pt_store) begin
              cnt_q <= cnt_q + NW'(1);
            end
          end
        end
        S_CLR: begin
          k_q <= k_q + BW'(1);
          if (k_q == BW'(MAX_BINS - 1)) begin
            k_q     <= '0;
            least_q <= LEAST_RESET;
            great_q <= '0;
            pass_q  <= 1'b0;
            i_q     <= '0;
            j_q     <= IW'(1);
            state_q <= (n_q < NW'(2)) ? S_NBS : S_RD;
          end
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_SUM;
        S_SUM: state_q <= S_SQ;
        S_SQ: begin
          if (sq_done) begin
            if (pass_q) begin
              state_q <= S_DIVB;
            end else begin
              if (d_w < least_q) least_q <= d_w;
              if (d_w > great_q) great_q <= d_w;
              if (more_j) begin
                j_q     <= j_q + IW'(1);
                state_q <= S_RD;
              end else if (more_i) begin
                i_q     <= i_q + IW'(1);
                j_q     <= i_q + IW'(2);
                state_q <= S_RD;
              end else begin
                state_q <= S_NBS;
              end
            end
          end
        end
        S_DIVB: if (dv_done) state_q <= S_BRD;
        S_BRD: begin
          if (more_j) begin
            j_q     <= j_q + IW'(1);
            state_q <= S_RD;
          end else if (more_i) begin
            i_q     <= i_q + IW'(1);
            j_q     <= i_q + IW'(2);
            state_q <= S_RD;
          end else begin
            k_q     <= '0;
            state_q <= S_ORA;
          end
        end
        S_NBS: state_q <= S_NBD;
        S_NBD: begin
          if (dv_done) begin
            // bin count clamped to 1..MAX_BINS
            if (dv_quot == '0) begin
              nbins_q <= NBW'(1);
            end else if (dv_quot > DIV_NW'(MAX_BINS)) begin
              nbins_q <= NBW'(MAX_BINS);
            end else begin
              nbins_q <= NBW'(dv_quot);
            end
            pass_q  <= 1'b1;
            i_q     <= '0;
            j_q     <= IW'(1);
            k_q     <= '0;
            state_q <= (n_q < NW'(2)) ? S_ORA : S_RD;
          end
        end
        S_ORA: state_q <= S_ORD;
        S_ORD: state_q <= (rc_q == '0) ? S_OUT : S_OD1;
        S_OD1: if (dv_done) state_q <= S_OD2;
        S_OD2: if (dv_done) state_q <= S_OUT;
        S_OUT: begin
          if (bin_o.ready) begin
            if (last_k) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + BW'(1);
              state_q <= S_ORA;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  esvb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (RAD_W'({(SQ_W'(sqx_q) + SQ_W'(sqy_q)), 16'h0000})),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  esvb_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  // result port
  assign bin_o.valid             = (state_q == S_OUT);
  assign bin_o.bin_index         = BIN_IDX_W'(k_q);
  assign bin_o.pair_count        = CNT_OUT_W'(rc_q);
  assign bin_o.mean_distance     = md_q;
  assign bin_o.mean_semivariance = ms_q;
  assign bin_o.last_bin          = last_k;

  // checks
  `ESVB_ASSERT_IMP(a_no_load_during_out, clk_i, rst_ni, bin_o.valid, !point_i.ready,
                   "point load open while a bin result is pending")
  `ESVB_ASSERT_IMP(a_pair_order, clk_i, rst_ni, state_q == S_RD,
                   (i_q < j_q) && (NW'(j_q) < n_q), "pair indices out of order")
  `ESVB_ASSERT_IMP(a_bin_in_range, clk_i, rst_ni, state_q == S_BRD,
                   NBW'(bidx_q) < nbins_q, "bin update beyond bin count")
  `ESVB_ASSERT_NXT(a_sqrt_wait, clk_i, rst_ni, sq_start, state_q == S_SQ,
                   "root started outside the pair sequence")

endmodule

// ===== verif/empirical_semivariogram_binner_tb.sv =====
module empirical_semivariogram_binner_tb;
  import esvb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 64;
  localparam int MAX_BINS   = 64;
  // Slack after the last result before a lag write or the end of the run.
  localparam int SETTLE_CYCLES = 400;

  // One bin report as seen on the result channel.
  typedef struct packed {
    logic [BIN_IDX_W-1:0] idx;
    logic [CNT_OUT_W-1:0] cnt;
    logic [MEAN_D_W-1:0]  mdist;
    logic [MEAN_S_W-1:0]  msemi;
    logic                 last;
  } bin_rpt_t;

  // Directed stimulus row; typed rows carry the single bin report they close with.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [VAL_W-1:0]   v;
    bit                        last;
    bit                        typed;
    bin_rpt_t                  rpt;
  } point_row_t;

  logic clk_i;
  logic rst_ni;

  esvb_point_if pt_if ();
  esvb_cfg_if   cf_if ();
  esvb_bin_if   bn_if ();

  empirical_semivariogram_binner #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_BINS  (MAX_BINS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(pt_if),
    .cfg_i  (cf_if),
    .bin_o  (bn_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the point store and of lag_width.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] set_x [MAX_POINTS];
  logic signed [COORD_W-1:0] set_y [MAX_POINTS];
  logic signed [VAL_W-1:0]   set_v [MAX_POINTS];
  int unsigned               set_cnt;
  logic [LAG_W-1:0]          lag_cur;

  bin_rpt_t bin_q[$];      // bin reports still owed by the block
  int       fail_cnt;
  int       points_sent;
  int       sets_closed;
  int       bins_seen;

  // Handshake pacing knobs, changed per phase.
  int idle_pct;
  int stall_pct;
  int hold_left;           // long receiver hold-off, counted down in the receiver

  // Integer square root, digit-by-digit.
  function automatic longint unsigned root64(longint unsigned val);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv >>= 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned absdiff16(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  // Q.8 pair distance, one LSB below the true root, floored at zero.
  function automatic longint unsigned pair_dist(int i, int j);
    longint unsigned dx, dy, r;
    dx = absdiff16(set_x[i], set_x[j]);
    dy = absdiff16(set_y[i], set_y[j]);
    r  = root64((dx * dx + dy * dy) << 16);
    return (r > 0) ? r - 1 : 0;
  endfunction

  // Close the set: walk every pair, bin it, queue one report per bin.
  function automatic void bin_point_set(ref bin_rpt_t rpts[$]);
    longint unsigned least, most, lo, hi, lagv, nb, d, dv, b, c;
    longint unsigned cnt [MAX_BINS];
    longint unsigned dsum[MAX_BINS];
    longint unsigned ssum[MAX_BINS];
    int              n;
    bin_rpt_t        r;
    n     = set_cnt;
    lagv  = (lag_cur == 0) ? 1 : lag_cur;
    least = LEAST_RESET;
    most  = 0;
    for (int k = 0; k < MAX_BINS; k++) begin
      cnt[k] = 0; dsum[k] = 0; ssum[k] = 0;
    end
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++) begin
        d = pair_dist(i, j);
        if (d < least) least = d;
        if (d > most)  most  = d;
      end
    if (n < 2) begin
      lo = 0; hi = 0;
    end else begin
      lo = least >> 8;
      hi = (most + 255) >> 8;
    end
    nb = (hi - lo) / lagv;
    if (nb < 1) nb = 1;
    if (nb > MAX_BINS) nb = MAX_BINS;
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++) begin
        d  = pair_dist(i, j);
        dv = absdiff16(set_v[i], set_v[j]);
        b  = ((d >> 8) - lo) / lagv;
        if (b > nb - 1) b = nb - 1;
        cnt[b]++;
        dsum[b] += d;
        ssum[b] += dv * dv;
      end
    for (int k = 0; k < nb; k++) begin
      c       = cnt[k];
      r.idx   = BIN_IDX_W'(k);
      r.cnt   = c[CNT_OUT_W-1:0];
      r.mdist = c ? MEAN_D_W'(dsum[k] / c) : '0;
      r.msemi = c ? MEAN_S_W'(ssum[k] / c) : '0;
      r.last  = (k + 1 == nb);
      rpts.push_back(r);
    end
    set_cnt = 0;
  endfunction

  // Record an accepted point; a full store drops it but last_point still closes.
  task automatic take_point(point_row_t p);
    bin_rpt_t rpts[$];
    if (set_cnt < MAX_POINTS) begin
      set_x[set_cnt] = p.x;
      set_y[set_cnt] = p.y;
      set_v[set_cnt] = p.v;
      set_cnt++;
    end
    if (p.last) begin
      bin_point_set(rpts);
      sets_closed++;
      // typed rows carry their own report, which replaces the computed one
      if (p.typed) bin_q.push_back(p.rpt);
      else foreach (rpts[k]) bin_q.push_back(rpts[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus an occasional long hold-off, then check
  // each transfer against the oldest queued report.
  // ---------------------------------------------------------------------------
  initial bn_if.ready = 1'b0;

  always @(posedge clk_i) begin
    bin_rpt_t e;
    if (rst_ni) begin
      if (bn_if.valid && bn_if.ready) begin
        bins_seen++;
        if (bin_q.size() == 0) begin
          $error("unexpected bin transfer, bin_index %0d", bn_if.bin_index);
          fail_cnt++;
        end else begin
          e = bin_q.pop_front();
          if (bn_if.bin_index !== e.idx) begin
            $error("bin_index: expected %0d, got %0d", e.idx, bn_if.bin_index);
            fail_cnt++;
          end
          if (bn_if.pair_count !== e.cnt) begin
            $error("pair_count: expected %0d, got %0d", e.cnt, bn_if.pair_count);
            fail_cnt++;
          end
          if (bn_if.mean_distance !== e.mdist) begin
            $error("mean_distance: expected %0d, got %0d", e.mdist, bn_if.mean_distance);
            fail_cnt++;
          end
          if (bn_if.mean_semivariance !== e.msemi) begin
            $error("mean_semivariance: expected %0d, got %0d", e.msemi,
                   bn_if.mean_semivariance);
            fail_cnt++;
          end
          if (bn_if.last_bin !== e.last) begin
            $error("last_bin: expected %0d, got %0d", e.last, bn_if.last_bin);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        bn_if.ready <= 1'b0;
      end else begin
        bn_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point side
  // ---------------------------------------------------------------------------
  // valid is lowered by send_point only inside the idle loop, so back-to-back transfers keep it
  // high without a same-step drop and raise.
  task automatic send_point(point_row_t p);
    while ($urandom_range(99) < idle_pct) begin
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_if.valid        <= 1'b1;
    pt_if.x_coord      <= p.x;
    pt_if.y_coord      <= p.y;
    pt_if.sample_value <= p.v;
    pt_if.last_point   <= p.last;
    do @(posedge clk_i); while (!pt_if.ready);
    points_sent++;
    take_point(p);
  endtask

  task automatic wait_drained();
    pt_if.valid <= 1'b0;
    while (bin_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Lag write; only called with the block idle.
  task automatic write_lag(logic [LAG_W-1:0] val);
    cf_if.valid     <= 1'b1;
    cf_if.lag_width <= val;
    do @(posedge clk_i); while (!cf_if.ready);
    cf_if.valid <= 1'b0;
    lag_cur = val;
  endtask

  // Random point set. Clustered sets keep bin counts low; wide ones hit the
  // extremes of the coordinate range.
  task automatic send_random_set(int n, bit wide);
    point_row_t p;
    int         span;
    span = $urandom_range(3, 60);
    for (int k = 0; k < n; k++) begin
      if (wide) begin
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
      end else begin
        p.x = COORD_W'(int'($urandom_range(2 * span)) - span);
        p.y = COORD_W'(int'($urandom_range(2 * span)) - span);
      end
      p.v     = VAL_W'($urandom);
      p.last  = (k == n - 1);
      p.typed = 1'b0;
      p.rpt   = '0;
      send_point(p);
    end
  endtask

  // Random phase: mostly small complete sets with random content, a few odd sizes.
  task automatic random_phase(int items);
    int start, n, r;
    start = points_sent;
    while (points_sent - start < items) begin
      r = $urandom_range(99);
      if (r < 80)      n = $urandom_range(2, 6);
      else if (r < 90) n = 1;
      else             n = $urandom_range(7, 12);
      send_random_set(n, $urandom_range(99) < 30);
    end
  endtask

  point_row_t dir_tbl[] = '{
    // lone point: no pairs, one empty bin
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{6'd0, 11'd0, 25'd0, 32'd0, 1'b1}},
    // coincident points, widest value gap
    '{16'sd5, 16'sd5, -16'sd32768, 1'b0, 1'b0, '0},
    '{16'sd5, 16'sd5, 16'sd32767, 1'b1, 1'b1, '{6'd0, 11'd1, 25'd0, 32'd4294836225, 1'b1}},
    // opposite corners of the grid
    '{-16'sd32768, -16'sd32768, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 16'sd0, 1'b1, 1'b0, '0},
    '{-16'sd32768, 16'sd32767, 16'sd100, 1'b0, 1'b0, '0},
    '{16'sd32767, -16'sd32768, -16'sd100, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b0, '0},
    '{16'sd3, 16'sd4, 16'sd2, 1'b0, 1'b0, '0},
    '{16'sd6, 16'sd8, -16'sd3, 1'b0, 1'b0, '0},
    '{16'sd1, 16'sd1, 16'sd7, 1'b1, 1'b0, '0},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0, '0},
    '{16'sd1, 16'sd1, 16'sd1, 1'b1, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pt_if.valid        = 1'b0;
    pt_if.x_coord      = '0;
    pt_if.y_coord      = '0;
    pt_if.sample_value = '0;
    pt_if.last_point   = 1'b0;
    cf_if.valid        = 1'b0;
    cf_if.lag_width    = '0;
    set_cnt     = 0;
    lag_cur     = 1;   // lag_width after reset
    fail_cnt    = 0;
    points_sent = 0;
    sets_closed = 0;
    bins_seen   = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_left   = 0;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset lag, full rate.
    foreach (dir_tbl[k]) send_point(dir_tbl[k]);
    wait_drained();

    // Widest bins, no pacing.
    write_lag(8'd255);
    random_phase(65);
    wait_drained();

    // Zero lag acts as one; sender idles a lot.
    write_lag(8'd0);
    idle_pct = 55;
    random_phase(65);
    wait_drained();

    // Receiver stalls a lot.
    write_lag(LAG_W'($urandom_range(2, 254)));
    idle_pct  = 0;
    stall_pct = 55;
    random_phase(65);
    wait_drained();

    // Both sides pace.
    write_lag(8'd1);
    idle_pct  = 31;
    stall_pct = 31;
    random_phase(65);
    wait_drained();

    // Backpressure: hold results off while the next sets keep coming,
    // so the block stays busy with its results and stalls its input.
    write_lag(LAG_W'($urandom_range(1, 8)));
    idle_pct  = 0;
    stall_pct = 0;
    send_random_set(6, 1'b1);
    hold_left = 3000;
    random_phase(30);
    wait_drained();

    // Full store, then a set that overflows it; its last point is dropped but still closes the set.
    write_lag(LAG_W'($urandom_range(1, 255)));
    send_random_set(MAX_POINTS, 1'b0);
    send_random_set(MAX_POINTS + 2, 1'b1);
    random_phase(30);
    wait_drained();

    $display("Covered %0d point transfers in %0d sets, %0d bin reports checked,",
             points_sent, sets_closed, bins_seen);
    $display("over lag widths 0, 1, 255 and random, with idle, stall and hold-off phases.");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
